// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/segscan_pkg.sv -----
// Shared types, constants and lookup functions of the segment scan serializer.
`timescale 1ns / 1ps

package segscan_pkg;

	localparam int WORD_BITS_DEF = 16;
	localparam int CODE_BITS     = 12;
	localparam int MV_BITS       = 14;
	localparam int SCAN_BITS     = 3;
	localparam int SEG_BITS      = 8;
	localparam int FRAC_BITS     = 12;
	localparam int RECIP_BITS    = 25;
	localparam int RECIP_SHIFT   = 24;

	localparam logic [MV_BITS-1:0]  REF_RESET = MV_BITS'(5000);
	localparam logic [SEG_BITS-1:0] DP_MASK   = 8'hFE;
	localparam logic [SEG_BITS-1:0] SEG_KEEP  = 8'hFF;
	localparam logic [15:0]         RECIP_TEN = 16'd52429;
	localparam int                  TEN_SHIFT = 19;

	localparam logic [1:0] DIG_THOUSANDS = 2'd0;
	localparam logic [1:0] DIG_HUNDREDS  = 2'd1;
	localparam logic [1:0] DIG_TENS      = 2'd2;
	localparam logic [1:0] DIG_ONES      = 2'd3;

	typedef struct packed {
		logic                 req_type;
		logic [CODE_BITS-1:0] adc_sample;
	} in_item_t;

	typedef struct packed {
		logic data_bit;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] raw_code;
		logic [MV_BITS-1:0]   millivolts;
		logic [SCAN_BITS-1:0] scan_index;
	} state_t;

	typedef struct packed {
		logic                 sample_we;
		logic [CODE_BITS-1:0] sample;
		logic                 tick;
	} upd_t;

	function automatic logic [RECIP_BITS-1:0] recip_of(input logic [1:0] which);
		logic [RECIP_BITS-1:0] r;
		unique case (which)
			DIG_THOUSANDS: r = RECIP_BITS'(16778);
			DIG_HUNDREDS:  r = RECIP_BITS'(167773);
			DIG_TENS:      r = RECIP_BITS'(1677722);
			DIG_ONES:      r = RECIP_BITS'(16777216);
		endcase
		return r;
	endfunction

	function automatic logic [SEG_BITS-1:0] seg_of(input logic [3:0] digit);
		logic [SEG_BITS-1:0] s;
		unique case (digit)
			4'd0:    s = 8'h03;
			4'd1:    s = 8'h9F;
			4'd2:    s = 8'h25;
			4'd3:    s = 8'h0D;
			4'd4:    s = 8'h99;
			4'd5:    s = 8'h49;
			4'd6:    s = 8'h41;
			4'd7:    s = 8'h1F;
			4'd8:    s = 8'h01;
			4'd9:    s = 8'h09;
			default: s = 8'hFF;
		endcase
		return s;
	endfunction

endpackage

// ----- hdl/segscan_regs.sv -----
// Reference register, stored sample, millivolt value and scan index.
`timescale 1ns / 1ps

module segscan_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [segscan_pkg::MV_BITS-1:0] cfg_wr_data,
	input  segscan_pkg::upd_t              upd,
	output segscan_pkg::state_t            st
);
	import segscan_pkg::*;

	logic [MV_BITS-1:0]           reference_q;
	logic [CODE_BITS-1:0]         raw_code_q;
	logic [MV_BITS-1:0]           millivolts_q;
	logic [SCAN_BITS-1:0]         scan_q;
	logic [CODE_BITS+MV_BITS-1:0] mv_prod;

	assign mv_prod = upd.sample * reference_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_q  <= REF_RESET;
			raw_code_q   <= '0;
			millivolts_q <= '0;
			scan_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				reference_q <= cfg_wr_data;
			end
			if (upd.sample_we) begin
				raw_code_q   <= upd.sample;
				millivolts_q <= mv_prod[FRAC_BITS +: MV_BITS];
			end
			if (upd.tick) begin
				scan_q <= scan_q + SCAN_BITS'(1);
			end
		end
	end

	assign st.raw_code   = raw_code_q;
	assign st.millivolts = millivolts_q;
	assign st.scan_index = scan_q;

endmodule

// ----- hdl/segscan_digit.sv -----
// Input register, digit quotient stage and display word builder.
`timescale 1ns / 1ps

module segscan_digit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  segscan_pkg::in_item_t    in_data,
	input  segscan_pkg::state_t      st,
	output segscan_pkg::upd_t        upd,
	input  logic                     load_ok,
	output logic                     word_load,
	output logic [2*segscan_pkg::SEG_BITS-1:0] word
);
	import segscan_pkg::*;

	localparam int PROD_A_BITS = MV_BITS + RECIP_BITS;
	localparam int PROD_B_BITS = MV_BITS + 16;
	localparam int TQ_BITS     = PROD_B_BITS - TEN_SHIFT;

	in_item_t             in_s1;
	logic                 vld_s1;
	logic [MV_BITS-1:0]   q_s2;
	logic [SCAN_BITS-1:0] pos_s2;
	logic                 dp_s2;
	logic                 vld_s2;

	logic                   s1_adv;
	logic                   s2_adv;
	logic [MV_BITS-1:0]     value;
	logic [PROD_A_BITS-1:0] prod_a;
	logic [PROD_B_BITS-1:0] prod_b;
	logic [TQ_BITS-1:0]     tq;
	logic [MV_BITS-1:0]     rem;
	logic [SEG_BITS-1:0]    seg;
	logic [SEG_BITS-1:0]    sel;

	assign s2_adv   = vld_s2 && load_ok;
	assign s1_adv   = vld_s1 && (!in_s1.req_type || !vld_s2 || s2_adv);
	assign in_stall = vld_s1 && !s1_adv;

	assign upd.sample_we = s1_adv && !in_s1.req_type;
	assign upd.sample    = in_s1.adc_sample;
	assign upd.tick      = s1_adv && in_s1.req_type;

	assign value  = st.scan_index[2] ? st.millivolts : MV_BITS'(st.raw_code);
	assign prod_a = value * recip_of(st.scan_index[1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				vld_s1 <= in_valid;
			end
			if (upd.tick) begin
				vld_s2 <= 1'b1;
			end else if (s2_adv) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_s1 <= in_data;
		end
		if (upd.tick) begin
			q_s2   <= prod_a[RECIP_SHIFT +: MV_BITS];
			pos_s2 <= {st.scan_index[2], ~st.scan_index[1:0]};
			dp_s2  <= (st.scan_index == SCAN_BITS'(4));
		end
	end

	assign prod_b = q_s2 * RECIP_TEN;
	assign tq     = prod_b[TEN_SHIFT +: TQ_BITS];
	assign rem    = q_s2 - MV_BITS'({tq, 3'b000}) - MV_BITS'({tq, 1'b0});
	assign seg    = seg_of(rem[3:0]) & (dp_s2 ? DP_MASK : SEG_KEEP);
	assign sel    = SEG_BITS'(1) << pos_s2;

	assign word_load = s2_adv;
	assign word      = {sel, seg};

endmodule

// ----- hdl/segscan_shifter.sv -----
// Serial shift register that sends one display word a bit per transfer.
`timescale 1ns / 1ps

module segscan_shifter #(
	parameter int WORD_BITS = segscan_pkg::WORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [WORD_BITS-1:0]   word,
	output logic                   load_ok,
	output logic                   out_valid,
	input  logic                   out_stall,
	output segscan_pkg::out_item_t out_data
);
	import segscan_pkg::*;

	localparam int CW = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] word_q;
	logic [CW-1:0]        cnt_q;
	logic                 valid_q;
	logic                 last;
	logic                 xfer;

	assign last    = (cnt_q == CW'(WORD_BITS - 1));
	assign xfer    = valid_q && !out_stall;
	assign load_ok = !valid_q || (xfer && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				cnt_q   <= '0;
			end else if (xfer) begin
				valid_q <= !last;
				cnt_q   <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word;
		end else if (xfer) begin
			word_q <= word_q >> 1;
		end
	end

	assign out_valid         = valid_q;
	assign out_data.data_bit = word_q[0];
	assign out_data.last     = last;

endmodule

// ----- hdl/seven_segment_scan_serializer.sv -----
// Top level of the multiplexed seven-segment scan serializer.
// A sample item stores the converter code and its millivolt value; it gives
// no output. A tick item yields one 16-bit display word (digit select in the
// high byte, active-low segments in the low byte), sent least significant bit
// first, one bit per output transfer, with last on the sixteenth bit. Items
// are taken every cycle while the pipeline has room. A tick passes the input
// register and the digit quotient stage to the single serial shift register,
// which takes a word only when idle or as its last bit is sent. A sample
// following a tick is taken at once while that tick is in the quotient stage.
`timescale 1ns / 1ps

module seven_segment_scan_serializer #(
	parameter int WORD_BITS = segscan_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [segscan_pkg::MV_BITS-1:0] cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  segscan_pkg::in_item_t           in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output segscan_pkg::out_item_t          out_data
);
	import segscan_pkg::*;

	state_t                  st;
	upd_t                    upd;
	logic                    load_ok;
	logic                    word_load;
	logic [2*SEG_BITS-1:0]   word;

	segscan_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.upd         (upd),
		.st          (st)
	);

	segscan_digit u_digit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.st        (st),
		.upd       (upd),
		.load_ok   (load_ok),
		.word_load (word_load),
		.word      (word)
	);

	segscan_shifter #(
		.WORD_BITS (WORD_BITS)
	) u_shifter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (word_load),
		.word      (WORD_BITS'(word)),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- hdl/segscan_checker.sv -----
// Port-level assertions for the scan serializer and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module segscan_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_stall,
	input segscan_pkg::out_item_t out_data
);
	import segscan_pkg::*;

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output bit changed")
	`ASSERT_NEXT(a_word_cont, out_valid && !out_stall && !out_data.last, out_valid, "word broken before its last bit")
	`ASSERT_NOW(a_word_start, $rose(out_valid), !out_data.last, "word starts on its last bit")
	`ASSERT_NEXT(a_last_once, out_valid && !out_stall && out_data.last, !(out_valid && out_data.last), "last bit repeated")

endmodule

bind seven_segment_scan_serializer segscan_checker u_chk (.*);

// ----- verif/seven_segment_scan_serializer_test.sv -----
// Self-checking testbench: queued random and directed traffic, serial bit prediction, stall bursts.
`timescale 1ns / 1ps

module seven_segment_scan_serializer_test;
	import segscan_pkg::*;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;
	localparam int   SETTLE_CYCLES  = 16;
	localparam int   WATCHDOG_LIMIT = 2000;
	localparam int   CHUNKS         = 8;
	localparam int   CHUNK_ITEMS    = 43;
	localparam logic [MV_BITS-1:0] REF_TOP  = '1;
	localparam logic [MV_BITS-1:0] REF_HIGH = MV_BITS'(9999);
	localparam logic [79:0] SEG_LUT = {
		8'h09, 8'h01, 8'h1F, 8'h41, 8'h49, 8'h99, 8'h0D, 8'h25, 8'h9F, 8'h03
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [MV_BITS-1:0] cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_item_t           in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_data;

	in_item_t  stim_queue[$];
	out_item_t expected_bits[$];
	int        fail_count = 0;
	int        quiet_cycles = 0;
	bit        idle_on = 1'b1;

	logic [MV_BITS-1:0]   ref_mv = REF_RESET;
	logic [SCAN_BITS-1:0] scan_pos = '0;
	logic [CODE_BITS-1:0] code_reg = '0;
	logic [MV_BITS-1:0]   mv_reg = '0;

	seven_segment_scan_serializer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic queue_item(input logic req, input logic [CODE_BITS-1:0] sample);
		in_item_t item;
		item.req_type = req;
		item.adc_sample = sample;
		stim_queue.push_back(item);
	endtask

	task automatic wait_idle();
		while (stim_queue.size() != 0 || in_valid || expected_bits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reference(input logic [MV_BITS-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ref_mv = value;
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		int gap_left;
		int value;
		int pos;
		int k;
		bit send;
		logic [3:0] digit;
		logic [15:0] word;
		in_item_t next_item;
		out_item_t exp_bit;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				if (in_data.req_type == REQ_SAMPLE) begin
					code_reg = in_data.adc_sample;
					mv_reg = MV_BITS'((int'(in_data.adc_sample) * int'(ref_mv)) >> FRAC_BITS);
				end else begin
					value = scan_pos[2] ? int'(mv_reg) : int'(code_reg);
					case (scan_pos[1:0])
						DIG_THOUSANDS: digit = 4'(value / 1000 % 10);
						DIG_HUNDREDS:  digit = 4'(value / 100 % 10);
						DIG_TENS:      digit = 4'(value / 10 % 10);
						default:       digit = 4'(value % 10);
					endcase
					word[7:0] = SEG_LUT[digit * 8 +: 8];
					// decimal point on the leading millivolt digit
					if (scan_pos == 3'd4)
						word[7:0] = word[7:0] & DP_MASK;
					pos = scan_pos[2] ? 7 - int'(scan_pos[1:0]) : 3 - int'(scan_pos[1:0]);
					word[15:8] = 8'(1 << pos);
					for (k = 0; k < 16; k++) begin
						exp_bit.data_bit = word[k];
						exp_bit.last = (k == 15);
						expected_bits.push_back(exp_bit);
					end
					scan_pos = scan_pos + 3'd1;
				end
			end
			if (!in_valid || !in_stall) begin
				send = 1'b0;
				if (gap_left > 0)
					gap_left--;
				else if (idle_on && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(0, 9);
				else if (stim_queue.size() != 0)
					send = 1'b1;
				if (send) begin
					next_item = stim_queue.pop_front();
					in_valid <= 1'b1;
					in_data <= next_item;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		int stall_left;
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bits.size() == 0) begin
					report_mismatch($sformatf("bit %b last %b with nothing expected",
						out_data.data_bit, out_data.last));
				end else begin
					want = expected_bits.pop_front();
					if (out_data.data_bit !== want.data_bit)
						report_mismatch($sformatf("data_bit %b, expected %b",
							out_data.data_bit, want.data_bit));
					if (out_data.last !== want.last)
						report_mismatch($sformatf("last %b, expected %b",
							out_data.last, want.last));
				end
			end
			if (stall_left > 0)
				stall_left--;
			else if (idle_on && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 10);
			out_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("FAIL seven_segment_scan_serializer");
		$finish;
	end

	initial begin : stimulus
		int chunk;
		int n;
		logic [CODE_BITS-1:0] code;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// blank state, then full-scale code at the reset reference
		queue_item(REQ_TICK, CODE_BITS'($urandom));
		queue_item(REQ_SAMPLE, '1);
		repeat (8) queue_item(REQ_TICK, CODE_BITS'($urandom));
		wait_idle();

		// reference above range: thousands digit wraps
		write_reference(REF_TOP);
		queue_item(REQ_SAMPLE, '1);
		repeat (5) queue_item(REQ_TICK, CODE_BITS'($urandom));
		wait_idle();

		write_reference('0);
		queue_item(REQ_SAMPLE, CODE_BITS'(2048));
		repeat (4) queue_item(REQ_TICK, CODE_BITS'($urandom));
		wait_idle();

		write_reference(REF_HIGH);
		queue_item(REQ_SAMPLE, '1);
		repeat (3) queue_item(REQ_TICK, CODE_BITS'($urandom));
		wait_idle();

		for (chunk = 0; chunk < CHUNKS; chunk++) begin
			idle_on = (chunk == CHUNKS - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
				0:       ;
				1:       write_reference(REF_TOP);
				2:       write_reference(REF_HIGH);
				3:       write_reference('0);
				default: write_reference(MV_BITS'($urandom_range(0, 9999)));
			endcase
			for (n = 0; n < CHUNK_ITEMS; n++) begin
				if ($urandom_range(0, 3) == 0) begin
					case ($urandom_range(0, 7))
						0:       code = '0;
						1:       code = '1;
						default: code = CODE_BITS'($urandom);
					endcase
					queue_item(REQ_SAMPLE, code);
				end else begin
					queue_item(REQ_TICK, CODE_BITS'($urandom));
				end
			end
			wait_idle();
		end

		if (fail_count == 0)
			$display("PASS seven_segment_scan_serializer");
		else
			$display("FAIL seven_segment_scan_serializer");
		$finish;
	end

endmodule
